FILE: design/pti_pkg.sv
// Shared types, field widths and constants for the pedestal time interpolator.
package pti_pkg;

    // Field widths of the command and result ports
    localparam int CMD_W      = 2;
    localparam int SLOT_W     = 6;
    localparam int CHAN_W     = 9;
    localparam int STAMP_W    = 32;
    localparam int VALUE_W    = 16;
    localparam int PED_W      = 16;
    localparam int INDEX_W    = 6;
    localparam int WEIGHT_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Defaults for the top-level parameters
    localparam int TIME_POINTS_DEF = 64;
    localparam int CHANNELS_DEF    = 512;
    localparam int STAMP_BITS_DEF  = 32;

    // Arithmetic constants
    localparam logic [WEIGHT_W-1:0] ONE_Q15      = 16'h8000;
    localparam logic [PED_W-1:0]    STATIC_RESET = 16'd5120;   // 20 dc, 8 fractional bits
    localparam logic [32:0]         ROUND_HALF   = 33'd16384;
    localparam int                  Q15_STEPS    = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLICES_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICES_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS      = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_TIME   = 2'd0,
        CMD_LOAD_SLICE  = 2'd1,
        CMD_LOAD_STATIC = 2'd2,
        CMD_QUERY       = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_T2,
        ST_DIV,
        ST_RD1,
        ST_RD2,
        ST_MUL,
        ST_SUM,
        ST_STATIC
    } state_t;

endpackage

FILE: design/pti_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module pti_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/pti_div.sv
// Restoring-style Q1.15 ratio unit: round(num / den), one quotient bit per cycle.
module pti_div #(
    parameter int WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          go,
    input  logic [WIDTH-1:0]              num,
    input  logic [WIDTH-1:0]              den,
    output logic                          done,
    output logic [pti_pkg::WEIGHT_W-1:0]  ratio
);

    import pti_pkg::*;

    localparam int CNT_W = $clog2(Q15_STEPS);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [WIDTH-1:0]    r_reg, r_next;
    logic [WIDTH-1:0]    b_reg, b_next;
    logic [WEIGHT_W-1:0] q_reg, q_next;
    logic [WEIGHT_W-1:0] ratio_reg, ratio_next;
    logic [WIDTH-1:0]    gap;
    logic [WEIGHT_W:0]   q_round;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        r_next     = r_reg;
        b_next     = b_reg;
        q_next     = q_reg;
        ratio_next = ratio_reg;
        gap        = b_reg - r_reg;
        q_round    = '0;

        if (go)
        begin
            if (num >= den)
            begin
                // ratio of one or more: clamp
                ratio_next = ONE_Q15;
                done_next  = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
                cnt_next  = '0;
                r_next    = num;
                b_next    = den;
                q_next    = '0;
            end
        end
        else if (busy_reg)
        begin
            // remainder stays below den, so neither branch overflows WIDTH
            if (r_reg >= gap)
            begin
                r_next = r_reg - gap;
                q_next = {q_reg[WEIGHT_W-2:0], 1'b1};
            end
            else
            begin
                r_next = r_reg + r_reg;
                q_next = {q_reg[WEIGHT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(Q15_STEPS - 1))
            begin
                busy_next  = 1'b0;
                done_next  = 1'b1;
                q_round    = {1'b0, q_next} + 1'b1;
                ratio_next = q_round[WEIGHT_W:1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg     <= r_next;
        b_reg     <= b_next;
        q_reg     <= q_next;
        ratio_reg <= ratio_next;
    end

    assign done  = done_reg;
    assign ratio = ratio_reg;

endmodule

FILE: design/pedestal_time_interpolator_top.sv
// Top level of the pedestal time interpolator: tables, query sequencer, result register.
//
//  channel   ports                                           beat marked by
//  -------   ---------------------------------------------   ------------------------
//  command   command low_gain slot channel stamp value       start high, busy low
//  result    pedestal first_index second_index first_weight  done high, one cycle
//            second_weight from_slices
//  config    cfg_we cfg_index cfg_data                       cfg_we high
//
// Loads finish in the cycle they are accepted; busy stays low and the next
// command beat can follow at once. A sliced query scans the n loaded time points
// through the single read port of the time-point RAM, one point per cycle, then
// runs the 16-step Q1.15 divider and two reads of the sliced RAM (the divider is
// skipped when the time clamps to an end point or no division is needed).
// After reset busy stays high while the static table is swept to 20 dc.
// The receiver cannot stall: each result stands for exactly one cycle.
module pedestal_time_interpolator_top #(
    parameter int TIME_POINTS = pti_pkg::TIME_POINTS_DEF,
    parameter int CHANNELS    = pti_pkg::CHANNELS_DEF,
    parameter int STAMP_BITS  = pti_pkg::STAMP_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // command channel
    input  logic                           start,
    output logic                           busy,
    input  logic [pti_pkg::CMD_W-1:0]      command,
    input  logic                           low_gain,
    input  logic [pti_pkg::SLOT_W-1:0]     slot,
    input  logic [pti_pkg::CHAN_W-1:0]     channel,
    input  logic [pti_pkg::STAMP_W-1:0]    stamp,
    input  logic [pti_pkg::VALUE_W-1:0]    value,
    // result channel
    output logic                           done,
    output logic [pti_pkg::PED_W-1:0]      pedestal,
    output logic [pti_pkg::INDEX_W-1:0]    first_index,
    output logic [pti_pkg::INDEX_W-1:0]    second_index,
    output logic [pti_pkg::WEIGHT_W-1:0]   first_weight,
    output logic [pti_pkg::WEIGHT_W-1:0]   second_weight,
    output logic                           from_slices,
    // configuration port
    input  logic                           cfg_we,
    input  logic [pti_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pti_pkg::CFG_DATA_W-1:0] cfg_data
);

    import pti_pkg::*;

    // Derived widths
    localparam int TW    = (STAMP_BITS < STAMP_W) ? STAMP_BITS : STAMP_W; // stored time width
    localparam int PW    = $clog2(TIME_POINTS);                            // slot index
    localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;          // channel index
    localparam int NW0   = $clog2(TIME_POINTS + 1);
    localparam int CNTW  = (NW0 > CFG_DATA_W) ? NW0 : CFG_DATA_W;          // point count
    localparam int CHX   = (CW > CHAN_W) ? CW : CHAN_W;
    localparam int SLX   = (PW > SLOT_W) ? PW : SLOT_W;
    localparam int IXW   = (PW > INDEX_W) ? PW : INDEX_W;
    localparam int SAW   = 1 + PW + CW;                                    // sliced RAM address
    localparam int STW   = 1 + CW;                                         // static RAM address

    // Control state
    state_t                  state_reg, state_next;
    logic                    cfg_hi_reg, cfg_hi_next;
    logic                    cfg_lo_reg, cfg_lo_next;
    logic [CFG_DATA_W-1:0]   cfg_n_reg, cfg_n_next;
    logic [STW-1:0]          clr_reg, clr_next;
    logic                    done_reg, done_next;
    logic [CNTW-1:0]         issue_reg, issue_next;
    logic                    rv_reg, rv_next;

    // Query context and datapath
    logic                    g_reg, g_next;
    logic [CHX-1:0]          ch_reg, ch_next;
    logic                    ch_ok_reg, ch_ok_next;
    logic [TW-1:0]           t_reg, t_next;
    logic [CNTW-1:0]         n_reg, n_next;
    logic [PW-1:0]           rk_reg, rk_next;
    logic                    found_reg, found_next;
    logic [TW-1:0]           best_reg, best_next;
    logic [PW-1:0]           i1_reg, i1_next;
    logic [PW-1:0]           i2_reg, i2_next;
    logic [TW-1:0]           t1_reg, t1_next;
    logic                    below_reg, below_next;
    logic                    above_reg, above_next;
    logic [WEIGHT_W-1:0]     w1_reg, w1_next;
    logic [WEIGHT_W-1:0]     w2_reg, w2_next;
    logic [PED_W-1:0]        p1_reg, p1_next;
    logic [31:0]             prod1_reg, prod1_next;
    logic [31:0]             prod2_reg, prod2_next;
    logic [PED_W-1:0]        ped_reg, ped_next;
    logic                    from_reg, from_next;

    // RAM ports
    logic                    tm_we;
    logic [PW-1:0]           tm_waddr, tm_raddr;
    logic [TW-1:0]           tm_rdata;
    logic                    sl_we;
    logic [SAW-1:0]          sl_waddr, sl_raddr;
    logic [PED_W-1:0]        sl_rdata;
    logic                    st_we;
    logic [STW-1:0]          st_waddr, st_raddr;
    logic [PED_W-1:0]        st_wdata, st_rdata;

    // Divider handshake
    logic                    div_go;
    logic                    div_done;
    logic [WEIGHT_W-1:0]     div_ratio;
    logic [TW-1:0]           div_num, div_den;

    // Input decode
    cmd_t                    cmd;
    logic [CHX-1:0]          ch_in;
    logic [SLX-1:0]          slot_in;
    logic                    slot_in_ok, ch_in_ok;
    logic [TW-1:0]           t_in;
    logic [CNTW-1:0]         n_in, nm1;
    logic                    use_in;

    // Scratch
    logic [TW-1:0]           dabs, den, anum;
    logic                    positive;
    logic [PED_W-1:0]        p2;
    logic [32:0]             acc;
    logic [IXW-1:0]          i1_ext, i2_ext;

    assign cmd        = cmd_t'(command);
    assign ch_in      = CHX'(channel);
    assign slot_in    = SLX'(slot);
    assign slot_in_ok = (32'(slot) < 32'(TIME_POINTS));
    assign ch_in_ok   = (32'(channel) < 32'(CHANNELS));
    assign t_in       = stamp[TW-1:0];
    assign n_in       = (32'(cfg_n_reg) > 32'(TIME_POINTS)) ? CNTW'(TIME_POINTS)
                                                             : CNTW'(cfg_n_reg);
    assign use_in     = low_gain ? cfg_lo_reg : cfg_hi_reg;
    assign nm1        = n_reg - 1'b1;

    // Configuration writes: ignore unknown indexes
    always_comb
    begin
        cfg_hi_next = cfg_hi_reg;
        cfg_lo_next = cfg_lo_reg;
        cfg_n_next  = cfg_n_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_SLICES_HIGH: cfg_hi_next = cfg_data[0];
                CFG_SLICES_LOW:  cfg_lo_next = cfg_data[0];
                CFG_POINTS:      cfg_n_next  = cfg_data;
                default:         ;
            endcase
        end
    end

    // Sequencer: next state, RAM ports and datapath
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        done_next  = 1'b0;
        issue_next = issue_reg;
        rv_next    = 1'b0;
        g_next     = g_reg;
        ch_next    = ch_reg;
        ch_ok_next = ch_ok_reg;
        t_next     = t_reg;
        n_next     = n_reg;
        rk_next    = rk_reg;
        found_next = found_reg;
        best_next  = best_reg;
        i1_next    = i1_reg;
        i2_next    = i2_reg;
        t1_next    = t1_reg;
        below_next = below_reg;
        above_next = above_reg;
        w1_next    = w1_reg;
        w2_next    = w2_reg;
        p1_next    = p1_reg;
        prod1_next = prod1_reg;
        prod2_next = prod2_reg;
        ped_next   = ped_reg;
        from_next  = from_reg;

        tm_we    = 1'b0;
        tm_waddr = slot_in[PW-1:0];
        tm_raddr = issue_reg[PW-1:0];
        sl_we    = 1'b0;
        sl_waddr = {low_gain, slot_in[PW-1:0], ch_in[CW-1:0]};
        sl_raddr = {g_reg, i1_reg, ch_reg[CW-1:0]};
        st_we    = 1'b0;
        st_waddr = {low_gain, ch_in[CW-1:0]};
        st_wdata = value;
        st_raddr = {low_gain, ch_in[CW-1:0]};

        div_go  = 1'b0;
        div_num = t_reg;
        div_den = t1_reg;

        dabs     = (tm_rdata >= t_reg) ? tm_rdata - t_reg : t_reg - tm_rdata;
        den      = (tm_rdata >= t1_reg) ? tm_rdata - t1_reg : t1_reg - tm_rdata;
        anum     = (t_reg >= t1_reg) ? t_reg - t1_reg : t1_reg - t_reg;
        positive = (t_reg > t1_reg) ? (tm_rdata > t1_reg) : (tm_rdata < t1_reg);
        p2       = ch_ok_reg ? sl_rdata : '0;
        acc      = 33'(prod1_reg) + 33'(prod2_reg) + ROUND_HALF;

        case (state_reg)
            ST_CLEAR:
            begin
                // sweep the static table to its reset value
                st_we    = 1'b1;
                st_waddr = clr_reg;
                st_wdata = STATIC_RESET;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    case (cmd)
                        CMD_LOAD_TIME:   tm_we = slot_in_ok;
                        CMD_LOAD_SLICE:  sl_we = slot_in_ok && ch_in_ok;
                        CMD_LOAD_STATIC: st_we = ch_in_ok;
                        CMD_QUERY:
                        begin
                            g_next     = low_gain;
                            ch_next    = ch_in;
                            ch_ok_next = ch_in_ok;
                            t_next     = t_in;
                            n_next     = n_in;
                            i1_next    = '0;
                            i2_next    = '0;
                            w1_next    = ONE_Q15;
                            w2_next    = '0;
                            issue_next = '0;
                            found_next = 1'b0;
                            below_next = 1'b0;
                            above_next = 1'b0;
                            if (use_in && (t_in != '0) && (n_in != '0))
                            begin
                                from_next  = 1'b1;
                                state_next = ST_SCAN;
                            end
                            else
                            begin
                                from_next  = 1'b0;
                                state_next = ST_STATIC;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ST_STATIC:
            begin
                ped_next   = ch_ok_reg ? st_rdata : '0;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            ST_SCAN:
            begin
                // issue one point per cycle, compare the one read last cycle
                if (issue_reg < n_reg)
                begin
                    issue_next = issue_reg + 1'b1;
                    rv_next    = 1'b1;
                    rk_next    = issue_reg[PW-1:0];
                end
                if (rv_reg)
                begin
                    if (rk_reg == '0)
                    begin
                        below_next = (t_reg < tm_rdata);
                    end
                    if (rk_reg == nm1[PW-1:0])
                    begin
                        above_next = (t_reg > tm_rdata);
                        state_next = ST_PICK;
                    end
                    // strict compare keeps the first point on a tie
                    if (!found_reg || (dabs < best_reg))
                    begin
                        found_next = 1'b1;
                        best_next  = dabs;
                        i1_next    = rk_reg;
                        t1_next    = tm_rdata;
                    end
                end
            end

            ST_PICK:
            begin
                if (below_reg)
                begin
                    i1_next    = '0;
                    i2_next    = '0;
                    w1_next    = ONE_Q15;
                    w2_next    = '0;
                    state_next = ST_RD1;
                end
                else if (above_reg)
                begin
                    i1_next    = nm1[PW-1:0];
                    i2_next    = nm1[PW-1:0];
                    w1_next    = '0;
                    w2_next    = ONE_Q15;
                    state_next = ST_RD1;
                end
                else
                begin
                    // neighbor on the side of the query time
                    if (t_reg > t1_reg)
                    begin
                        i2_next = (i1_reg < nm1[PW-1:0]) ? i1_reg + 1'b1 : nm1[PW-1:0];
                    end
                    else
                    begin
                        i2_next = (i1_reg > '0) ? i1_reg - 1'b1 : '0;
                    end
                    tm_raddr   = i2_next;
                    state_next = ST_T2;
                end
            end

            ST_T2:
            begin
                if ((den == '0) || !positive)
                begin
                    w1_next    = ONE_Q15;
                    w2_next    = '0;
                    state_next = ST_RD1;
                end
                else
                begin
                    div_go     = 1'b1;
                    div_num    = anum;
                    div_den    = den;
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    w2_next    = div_ratio;
                    w1_next    = ONE_Q15 - div_ratio;
                    state_next = ST_RD1;
                end
            end

            ST_RD1:
            begin
                sl_raddr   = {g_reg, i1_reg, ch_reg[CW-1:0]};
                state_next = ST_RD2;
            end

            ST_RD2:
            begin
                sl_raddr   = {g_reg, i2_reg, ch_reg[CW-1:0]};
                p1_next    = ch_ok_reg ? sl_rdata : '0;
                state_next = ST_MUL;
            end

            ST_MUL:
            begin
                prod1_next = 32'(w1_reg) * 32'(p1_reg);
                prod2_next = 32'(w2_reg) * 32'(p2);
                state_next = ST_SUM;
            end

            ST_SUM:
            begin
                // round, drop the Q1.15 scale, saturate to 16 bits
                ped_next   = (acc[32:31] != 2'b00) ? '1 : acc[30:15];
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            cfg_hi_reg <= 1'b1;
            cfg_lo_reg <= 1'b1;
            cfg_n_reg  <= '0;
            clr_reg    <= '0;
            done_reg   <= 1'b0;
            issue_reg  <= '0;
            rv_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cfg_hi_reg <= cfg_hi_next;
            cfg_lo_reg <= cfg_lo_next;
            cfg_n_reg  <= cfg_n_next;
            clr_reg    <= clr_next;
            done_reg   <= done_next;
            issue_reg  <= issue_next;
            rv_reg     <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        g_reg     <= g_next;
        ch_reg    <= ch_next;
        ch_ok_reg <= ch_ok_next;
        t_reg     <= t_next;
        n_reg     <= n_next;
        rk_reg    <= rk_next;
        found_reg <= found_next;
        best_reg  <= best_next;
        i1_reg    <= i1_next;
        i2_reg    <= i2_next;
        t1_reg    <= t1_next;
        below_reg <= below_next;
        above_reg <= above_next;
        w1_reg    <= w1_next;
        w2_reg    <= w2_next;
        p1_reg    <= p1_next;
        prod1_reg <= prod1_next;
        prod2_reg <= prod2_next;
        ped_reg   <= ped_next;
        from_reg  <= from_next;
    end

    // Time points, one per slot
    pti_ram #(
        .WIDTH (TW),
        .DEPTH (TIME_POINTS)
    ) u_time_ram (
        .clk   (clk),
        .we    (tm_we),
        .waddr (tm_waddr),
        .wdata (t_in),
        .raddr (tm_raddr),
        .rdata (tm_rdata)
    );

    // Sliced pedestals, addressed by gain, slot and channel
    pti_ram #(
        .WIDTH (PED_W),
        .DEPTH (2 ** SAW)
    ) u_slice_ram (
        .clk   (clk),
        .we    (sl_we),
        .waddr (sl_waddr),
        .wdata (value),
        .raddr (sl_raddr),
        .rdata (sl_rdata)
    );

    // Static pedestals, addressed by gain and channel
    pti_ram #(
        .WIDTH (PED_W),
        .DEPTH (2 ** STW)
    ) u_static_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    pti_div #(
        .WIDTH (TW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (div_go),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .ratio (div_ratio)
    );

    assign i1_ext = IXW'(i1_reg);
    assign i2_ext = IXW'(i2_reg);

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign pedestal      = ped_reg;
    assign first_index   = i1_ext[INDEX_W-1:0];
    assign second_index  = i2_ext[INDEX_W-1:0];
    assign first_weight  = w1_reg;
    assign second_weight = w2_reg;
    assign from_slices   = from_reg;

endmodule

FILE: tb/pedestal_time_interpolator_top_tb.sv
// Self-checking testbench for the pedestal time interpolator: loads, queries, config phases.
module pedestal_time_interpolator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pti_pkg::*;

    // Register index with no register behind it; writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam int          WATCHDOG_CYCLES = 5000;  // quiet cycles before giving up
    localparam int          SETTLE_CYCLES   = 4;     // loads retire in their own cycle
    localparam int          DRAIN_CYCLES    = 100;   // covers the longest query: a full-table scan and a divide
    localparam int          HOT_CHANNELS    = 8;
    localparam logic [63:0] FAR_DISTANCE    = 64'd1000000000000000;

    // How a phase lays out its time-point table.
    typedef enum int {
        SPREAD_SORTED,
        SPREAD_DUPLICATES,
        SPREAD_SHUFFLED,
        SPREAD_WIDE
    } spread_t;

    typedef struct packed {
        logic [PED_W-1:0]    pedestal;
        logic [INDEX_W-1:0]  first_index;
        logic [INDEX_W-1:0]  second_index;
        logic [WEIGHT_W-1:0] first_weight;
        logic [WEIGHT_W-1:0] second_weight;
        logic                from_slices;
    } ped_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [CMD_W-1:0]      command;
    logic                  low_gain;
    logic [SLOT_W-1:0]     slot;
    logic [CHAN_W-1:0]     channel;
    logic [STAMP_W-1:0]    stamp;
    logic [VALUE_W-1:0]    value;
    logic                  done;
    logic [PED_W-1:0]      pedestal;
    logic [INDEX_W-1:0]    first_index;
    logic [INDEX_W-1:0]    second_index;
    logic [WEIGHT_W-1:0]   first_weight;
    logic [WEIGHT_W-1:0]   second_weight;
    logic                  from_slices;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Mirror of the block: registers and the three tables.
    logic                  slices_hi;
    logic                  slices_lo;
    logic [CFG_DATA_W-1:0] points_reg;
    logic [STAMP_W-1:0]    point_time [TIME_POINTS_DEF];
    logic [PED_W-1:0]      slice_ped  [2][TIME_POINTS_DEF][CHANNELS_DEF];
    bit                    slice_set  [2][TIME_POINTS_DEF][CHANNELS_DEF];
    logic [PED_W-1:0]      static_ped [2][CHANNELS_DEF];

    ped_result_t        expected_q[$];
    ped_result_t        oldest;
    logic [CHAN_W-1:0]  hot_channel [HOT_CHANNELS];
    int                 mismatches   = 0;
    int                 burst_left   = 0;
    int                 quiet_cycles = 0;

    pedestal_time_interpolator_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .low_gain     (low_gain),
        .slot         (slot),
        .channel      (channel),
        .stamp        (stamp),
        .value        (value),
        .done         (done),
        .pedestal     (pedestal),
        .first_index  (first_index),
        .second_index (second_index),
        .first_weight (first_weight),
        .second_weight(second_weight),
        .from_slices  (from_slices),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [63:0] time_gap(input logic [63:0] a, input logic [63:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic logic [STAMP_W-1:0] clamp_stamp(input logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? '1 : v[STAMP_W-1:0];
    endfunction

    // Register values above the table depth act as a full table.
    function automatic int active_points();
        return (points_reg > TIME_POINTS_DEF) ? TIME_POINTS_DEF : int'(points_reg);
    endfunction

    // Work out what a query returns against the current table contents.
    function automatic ped_result_t interpolate(input bit g, input logic [CHAN_W-1:0] ch,
                                                input logic [STAMP_W-1:0] t);
        ped_result_t     r;
        int              n;
        int              k;
        int              near_k;
        int              side_k;
        bit              enabled;
        logic [63:0]     best;
        logic [63:0]     gap_now;
        logic [63:0]     t1;
        logic [63:0]     t2;
        logic [63:0]     span;
        logic [63:0]     offset;
        logic [63:0]     acc;
        logic [WEIGHT_W-1:0] w2;
        n       = active_points();
        enabled = g ? slices_lo : slices_hi;
        r.pedestal      = static_ped[g][ch];
        r.first_index   = '0;
        r.second_index  = '0;
        r.first_weight  = ONE_Q15;
        r.second_weight = '0;
        r.from_slices   = 1'b0;
        // Static path: slices off for this gain, zero time, or an empty table.
        if (!enabled || t == '0 || n == 0)
            return r;
        r.from_slices = 1'b1;
        if (t < point_time[0])
        begin
            near_k = 0;
            side_k = 0;
            w2     = '0;
        end
        else if (t > point_time[n-1])
        begin
            near_k = n - 1;
            side_k = n - 1;
            w2     = ONE_Q15;
        end
        else
        begin
            // Strict compare: on a tie the earliest point keeps the win.
            best   = FAR_DISTANCE;
            near_k = 0;
            for (k = 0; k < n; k++)
            begin
                gap_now = time_gap(point_time[k], t);
                if (gap_now < best)
                begin
                    best   = gap_now;
                    near_k = k;
                end
            end
            t1 = point_time[near_k];
            if (t > t1)
                side_k = (near_k < n - 1) ? near_k + 1 : n - 1;
            else
                side_k = (near_k > 0) ? near_k - 1 : 0;
            t2   = point_time[side_k];
            span = time_gap(t2, t1);
            w2   = '0;
            // A neighbor on the wrong side (unsorted table) gets no weight.
            if (span != 0 && ((t > t1) ? (t2 > t1) : (t2 < t1)))
            begin
                offset = time_gap(t, t1);
                if (offset >= span)
                    w2 = ONE_Q15;
                else
                    w2 = (((offset << 16) / span) + 1) >> 1;
            end
        end
        r.first_index   = INDEX_W'(near_k);
        r.second_index  = INDEX_W'(side_k);
        r.second_weight = w2;
        r.first_weight  = ONE_Q15 - w2;
        acc = 64'(r.first_weight) * 64'(slice_ped[g][near_k][ch])
            + 64'(w2) * 64'(slice_ped[g][side_k][ch]) + 64'(ROUND_HALF);
        acc = acc >> 15;
        r.pedestal = (acc > 64'hFFFF) ? '1 : acc[PED_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------

    // Drive one command beat, hold it until accepted, then advance the mirror.
    // Start is left high on return; the next beat or wait_idle decides its fate.
    task automatic send_beat(input cmd_t cmd, input bit g, input logic [SLOT_W-1:0] s,
                             input logic [CHAN_W-1:0] ch, input logic [STAMP_W-1:0] t,
                             input logic [VALUE_W-1:0] v);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : $urandom_range(0, 4);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        start    <= 1'b1;
        command  <= cmd;
        low_gain <= g;
        slot     <= s;
        channel  <= ch;
        stamp    <= t;
        value    <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        case (cmd)
            CMD_LOAD_TIME:   point_time[s] = t;
            CMD_LOAD_SLICE:
            begin
                slice_ped[g][s][ch] = v;
                slice_set[g][s][ch] = 1'b1;
            end
            CMD_LOAD_STATIC: static_ped[g][ch] = v;
            CMD_QUERY:       expected_q.push_back(interpolate(g, ch, t));
            default: ;
        endcase
    endtask

    // Drop start, wait for every pending result and for the block to go quiet.
    task automatic wait_idle();
        start <= 1'b0;
        while (expected_q.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_SLICES_HIGH: slices_hi  = data[0];
            CFG_SLICES_LOW:  slices_lo  = data[0];
            CFG_POINTS:      points_reg = data;
            default: ;
        endcase
    endtask

    // Rewrite every register while idle; upper bits of the one-bit registers
    // and the spare index carry junk that must not land anywhere.
    task automatic program_config(input bit sh, input bit sl, input logic [CFG_DATA_W-1:0] pts);
        wait_idle();
        write_reg(CFG_SLICES_HIGH, {6'($urandom_range(0, 63)), sh});
        write_reg(CFG_SLICES_LOW,  {6'($urandom_range(0, 63)), sl});
        write_reg(CFG_POINTS, pts);
        write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        return VALUE_W'($urandom);
    endfunction

    function automatic logic [CHAN_W-1:0] pick_channel();
        if ($urandom_range(0, 4) == 0)
            return CHAN_W'($urandom);
        return hot_channel[$urandom_range(0, HOT_CHANNELS - 1)];
    endfunction

    // Query times: mostly in and around the loaded span, some exact hits,
    // zero, all-ones and fully random values.
    function automatic logic [STAMP_W-1:0] pick_stamp(input int n);
        int          roll;
        int          k;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] margin;
        logic [63:0] reach;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            return '0;
        if (roll < 8)
            return '1;
        if (n == 0 || roll < 15)
            return $urandom;
        if (roll < 35)
        begin
            k     = $urandom_range(0, n - 1);
            reach = 64'(point_time[k]) + $urandom_range(0, 2);
            return (reach == 0) ? '0 : clamp_stamp(reach - 1);
        end
        lo = point_time[0];
        hi = lo;
        for (k = 1; k < n; k++)
        begin
            if (point_time[k] < lo)
                lo = point_time[k];
            if (point_time[k] > hi)
                hi = point_time[k];
        end
        margin = (hi - lo) / 8 + 2;
        lo     = (lo > margin) ? lo - margin : 64'd0;
        hi     = hi + margin;
        reach  = lo + ({$urandom, $urandom} % (hi - lo + 1));
        return clamp_stamp(reach);
    endfunction

    // Load a sliced entry only if the coming query reads it and it was never written.
    task automatic fill_slice(input bit g, input logic [SLOT_W-1:0] s,
                              input logic [CHAN_W-1:0] ch);
        if (!slice_set[g][s][ch])
            send_beat(CMD_LOAD_SLICE, g, s, ch, $urandom, pick_value());
    endtask

    task automatic issue_query(input bit g, input logic [CHAN_W-1:0] ch,
                               input logic [STAMP_W-1:0] t);
        ped_result_t peek;
        peek = interpolate(g, ch, t);
        if (peek.from_slices)
        begin
            fill_slice(g, peek.first_index, ch);
            fill_slice(g, peek.second_index, ch);
        end
        send_beat(CMD_QUERY, g, SLOT_W'($urandom), ch, t, VALUE_W'($urandom));
    endtask

    task automatic load_points(input int count, input spread_t spread);
        logic [63:0] acc;
        int          k;
        case (spread)
            SPREAD_DUPLICATES: acc = $urandom_range(1, 1000);
            SPREAD_WIDE:       acc = $urandom_range(0, 1 << 30);
            default:           acc = $urandom_range(1, 1 << 24);
        endcase
        for (k = 0; k < count; k++)
        begin
            case (spread)
                SPREAD_SORTED:     acc = acc + $urandom_range(1, 1 << 20);
                SPREAD_DUPLICATES: acc = acc + (($urandom_range(0, 2) == 0) ?
                                                0 : $urandom_range(1, 50));
                SPREAD_SHUFFLED:   acc = $urandom;
                default:           acc = acc + $urandom_range(1 << 20, 1 << 25);
            endcase
            send_beat(CMD_LOAD_TIME, 1'($urandom), SLOT_W'(k), CHAN_W'($urandom),
                      clamp_stamp(acc), VALUE_W'($urandom));
        end
    endtask

    // One random beat: mostly queries, then pedestal loads and the odd
    // time-point rewrite that can leave the table unsorted.
    task automatic random_op(input int n);
        int roll;
        bit g;
        roll = $urandom_range(0, 99);
        g    = 1'($urandom);
        if (roll < 60)
            issue_query(g, pick_channel(), pick_stamp(n));
        else if (roll < 78)
            send_beat(CMD_LOAD_SLICE, g, SLOT_W'($urandom),
                      ($urandom_range(0, 1) == 0) ? pick_channel() : CHAN_W'($urandom),
                      $urandom, pick_value());
        else if (roll < 90)
            send_beat(CMD_LOAD_STATIC, g, SLOT_W'($urandom), pick_channel(), $urandom,
                      pick_value());
        else if (roll < 95)
            send_beat(CMD_LOAD_TIME, g, SLOT_W'($urandom), CHAN_W'($urandom),
                      pick_stamp(n), VALUE_W'($urandom));
        else
            issue_query(g, CHAN_W'($urandom), pick_stamp(n));
    endtask

    task automatic run_phase(input bit sh, input bit sl, input logic [CFG_DATA_W-1:0] pts,
                             input spread_t spread, input int ops);
        int n;
        program_config(sh, sl, pts);
        n = active_points();
        load_points(n, spread);
        repeat (ops) random_op(n);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty table after reset: every query falls back to the static table.
    task automatic test_reset_statics();
        issue_query(1'b0, 9'd0, '1);
        issue_query(1'b1, 9'd511, 32'd1234);
        send_beat(CMD_LOAD_STATIC, 1'b0, 6'd0, 9'd0, '0, '0);
        send_beat(CMD_LOAD_STATIC, 1'b1, 6'd63, 9'd511, '1, '1);
        issue_query(1'b0, 9'd0, 32'h8000_0000);
        issue_query(1'b1, 9'd511, '0);
    endtask

    // Four points with a duplicate; slice enables still at their reset values.
    task automatic test_small_table();
        wait_idle();
        write_reg(CFG_POINTS, 7'd4);
        cfg_we <= 1'b0;
        send_beat(CMD_LOAD_TIME, 1'b0, 6'd0, 9'd0, 32'd100, '0);
        send_beat(CMD_LOAD_TIME, 1'b1, 6'd1, 9'd0, 32'd200, '0);
        send_beat(CMD_LOAD_TIME, 1'b0, 6'd2, 9'd0, 32'd200, '0);
        send_beat(CMD_LOAD_TIME, 1'b1, 6'd3, 9'd0, 32'd400, '0);
        send_beat(CMD_LOAD_SLICE, 1'b0, 6'd0, 9'd5, '0, '0);
        send_beat(CMD_LOAD_SLICE, 1'b0, 6'd1, 9'd5, '0, '1);
        send_beat(CMD_LOAD_SLICE, 1'b0, 6'd2, 9'd5, '0, 16'h1234);
        send_beat(CMD_LOAD_SLICE, 1'b0, 6'd3, 9'd5, '0, '1);
        issue_query(1'b0, 9'd5, 32'd50);    // before the first point
        issue_query(1'b0, 9'd5, 32'd500);   // after the last point
        issue_query(1'b0, 9'd5, 32'd150);   // equidistant: earlier point wins
        issue_query(1'b0, 9'd5, 32'd200);   // exact hit on a duplicated time
        issue_query(1'b0, 9'd5, 32'd300);   // neighbor shares the nearest time
        issue_query(1'b0, 9'd5, '0);        // zero time takes the static path
    endtask

    // Table becomes 100, 300, 120, 400: neighbors on the wrong side.
    task automatic test_unsorted_table();
        send_beat(CMD_LOAD_TIME, 1'b0, 6'd1, 9'd0, 32'd300, '0);
        send_beat(CMD_LOAD_TIME, 1'b0, 6'd2, 9'd0, 32'd120, '0);
        issue_query(1'b1, 9'd5, 32'd115);
        issue_query(1'b1, 9'd5, 32'd250);
    endtask

    task automatic test_slices_disabled();
        program_config(1'b0, 1'b1, 7'd4);
        issue_query(1'b0, 9'd5, 32'd150);
        issue_query(1'b1, 9'd5, 32'd150);
        program_config(1'b1, 1'b0, 7'd4);
        issue_query(1'b1, 9'd5, 32'd150);
        issue_query(1'b0, 9'd5, 32'd150);
    endtask

    // Random traffic over a range of settings, both extremes of the point
    // count and a count above the table depth among them.
    task automatic test_random_phases();
        int k;
        hot_channel[0] = '0;
        hot_channel[1] = '1;
        for (k = 2; k < HOT_CHANNELS; k++)
            hot_channel[k] = CHAN_W'($urandom);
        run_phase(1'b1, 1'b1, 7'd64,  SPREAD_SORTED,     50);
        run_phase(1'b1, 1'b1, 7'd1,   SPREAD_SORTED,     50);
        run_phase(1'b0, 1'b1, 7'd37,  SPREAD_DUPLICATES, 50);
        run_phase(1'b1, 1'b0, 7'd64,  SPREAD_SHUFFLED,   50);
        run_phase(1'b0, 1'b0, 7'd20,  SPREAD_SORTED,     50);
        run_phase(1'b1, 1'b1, 7'd100, SPREAD_WIDE,       50);
        run_phase(1'b1, 1'b1, 7'd2,   SPREAD_DUPLICATES, 50);
        run_phase(1'b1, 1'b1, 7'd0,   SPREAD_SORTED,     50);
        run_phase(1'b1, 1'b1, 7'd64,  SPREAD_WIDE,       50);
        run_phase(1'b1, 1'b1, CFG_DATA_W'($urandom_range(3, 63)),
                  spread_t'($urandom_range(0, 3)), 50);
    endtask

    // ------------------------------------------------------------------
    // Result side: the receiver cannot stall, so check every strobe.
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result beat with no query waiting");
                mismatches++;
            end
            else
            begin
                oldest = expected_q.pop_front();
                check_field("pedestal", oldest.pedestal, pedestal);
                check_field("first_index", oldest.first_index, first_index);
                check_field("second_index", oldest.second_index, second_index);
                check_field("first_weight", oldest.first_weight, first_weight);
                check_field("second_weight", oldest.second_weight, second_weight);
                check_field("from_slices", oldest.from_slices, from_slices);
            end
        end
    end

    // Watchdog: count cycles with no beat on either side; the clearing pass
    // after reset is the longest legal quiet stretch.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $display("pedestal_time_interpolator_top_tb: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        int g;
        int ch;
        // Hold every input at a known value and bring the mirror to its reset state.
        rst_n     = 1'b0;
        start     = 1'b0;
        command   = CMD_LOAD_TIME;
        low_gain  = 1'b0;
        slot      = '0;
        channel   = '0;
        stamp     = '0;
        value     = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_SLICES_HIGH;
        cfg_data  = '0;
        slices_hi  = 1'b1;
        slices_lo  = 1'b1;
        points_reg = '0;
        for (g = 0; g < 2; g++)
            for (ch = 0; ch < CHANNELS_DEF; ch++)
                static_ped[g][ch] = STATIC_RESET;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_statics();
        test_small_table();
        test_unsorted_table();
        test_slices_disabled();
        test_random_phases();

        // Drain: every query answered, then let any stray strobe show up.
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("pedestal_time_interpolator_top_tb: PASS");
        else
            $display("pedestal_time_interpolator_top_tb: FAIL");
        $finish;
    end

endmodule
